@@ hdl/occ_pkg.sv @@
`default_nettype none

package occ_pkg;

    // Grid and window geometry
    localparam int GRID_SIDE_DEF     = 256;
    localparam int MAX_WINDOW_RADIUS = 4;
    localparam int RAD_IN_W          = 3;
    localparam int RAD_W             = $clog2(MAX_WINDOW_RADIUS + 1);
    localparam int RREQ_W            = (RAD_W > RAD_IN_W) ? RAD_W : RAD_IN_W;

    // Field and arithmetic widths
    localparam int POS_W  = 11;
    localparam int CRD_W  = 12;
    localparam int CELL_W = 9;
    localparam int SUM_W  = 11;

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;

    // Input mode codes
    localparam logic [1:0] MODE_HIT   = 2'd0;
    localparam logic [1:0] MODE_MISS  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // Cell values in hundredths
    localparam logic signed [CELL_W-1:0] CELL_UNKNOWN   = -9'sd100;
    localparam logic signed [CELL_W-1:0] CELL_FLOOR_PRE = -9'sd90;
    localparam logic signed [CELL_W-1:0] CELL_MIN       = -9'sd99;
    localparam logic signed [CELL_W-1:0] CELL_MAX       = 9'sd200;
    localparam logic signed [SUM_W-1:0]  CENTER_STEP    = 11'sd45;
    localparam logic signed [SUM_W-1:0]  NEIGHBOUR_STEP = 11'sd10;

    typedef enum logic [1:0] {
        CMD_FLAG,
        CMD_HIT,
        CMD_MISS,
        CMD_QUERY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                 kind;
        logic signed [POS_W-1:0]   x;
        logic signed [POS_W-1:0]   y;
        logic signed [CELL_W-1:0]  thr;
        logic [RAD_W-1:0]          rad;
        logic                      flag;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_QUERY,
        ST_DRAIN,
        ST_RESULT
    } back_state_t;

    function automatic logic in_grid(
        input logic signed [CRD_W-1:0] cx,
        input logic signed [CRD_W-1:0] cy,
        input logic signed [CRD_W-1:0] side
    );
        return (cx >= 0) && (cy >= 0) && (cx < side) && (cy < side);
    endfunction

    function automatic logic signed [CELL_W-1:0] clamp_cell(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [CELL_W-1:0] r;
        if (v < SUM_W'(CELL_MIN))
        begin
            r = CELL_MIN;
        end
        else if (v > SUM_W'(CELL_MAX))
        begin
            r = CELL_MAX;
        end
        else
        begin
            r = CELL_W'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/occupancy_costmap_update_query.sv @@
// An update reads and writes back the center, then its four neighbours; a query reads
// the window of effective radius r (r = 0 without the window), one cell per cycle; an
// out-of-bounds or unused command goes straight to the result. A new command starts
// only after the last result is registered. Up to two further items queue up while
// the back end works or the result waits. Reset: asynchronous, active low; then a
// clearing pass marks all GRID_SIDE*GRID_SIDE cells unknown while in_stall is high.
`default_nettype none

module occupancy_costmap_update_query import occ_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [1:0]                mode,
    input  wire logic signed [POS_W-1:0]   pos_x,
    input  wire logic signed [POS_W-1:0]   pos_y,
    input  wire logic signed [CELL_W-1:0]  threshold,
    input  wire logic                      use_window,
    input  wire logic [RAD_IN_W-1:0]       window_radius,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           flag
);

    // Front end: classify each item (bounds, radius saturation) and queue it.
    // Back end: run the cell read-modify-writes or the window scan on the RAM,
    // then hold the flag in the output register until it is taken.

    cmd_t front_cmd;
    cmd_t back_cmd;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    logic clearing;

    occ_front #(
        .GRID_SIDE (GRID_SIDE)
    ) u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .threshold     (threshold),
        .use_window    (use_window),
        .window_radius (window_radius),
        .clearing      (clearing),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (front_cmd)
    );

    // hold classified items until the back end is free
    occ_cmdq u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (back_cmd),
        .empty    (q_empty)
    );

    occ_back #(
        .GRID_SIDE (GRID_SIDE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_cmd     (back_cmd),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .flag      (flag)
    );

endmodule

`default_nettype wire

@@ hdl/occ_ram.sv @@
`default_nettype none

module occ_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/occ_front.sv @@
`default_nettype none

module occ_front import occ_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [1:0]                mode,
    input  wire logic signed [POS_W-1:0]   pos_x,
    input  wire logic signed [POS_W-1:0]   pos_y,
    input  wire logic signed [CELL_W-1:0]  threshold,
    input  wire logic                      use_window,
    input  wire logic [RAD_IN_W-1:0]       window_radius,
    input  wire logic                      clearing,
    input  wire logic                      q_full,
    output logic                           q_push,
    output cmd_t                           q_cmd
);

    localparam logic signed [CRD_W-1:0] SIDE_S  = CRD_W'(GRID_SIDE);
    localparam logic [RREQ_W-1:0]       RAD_CAP = RREQ_W'(MAX_WINDOW_RADIUS);

    logic               center_in;
    logic [RREQ_W-1:0]  rad_req;
    logic [RAD_W-1:0]   rad_sat;

    always_comb
    begin
        center_in = in_grid(CRD_W'(pos_x), CRD_W'(pos_y), SIDE_S);

        // saturate the window to the largest supported radius
        rad_req = RREQ_W'(window_radius);
        if (rad_req > RAD_CAP)
        begin
            rad_sat = RAD_W'(RAD_CAP);
        end
        else
        begin
            rad_sat = RAD_W'(rad_req);
        end

        q_cmd.x    = pos_x;
        q_cmd.y    = pos_y;
        q_cmd.thr  = threshold;
        q_cmd.rad  = use_window ? rad_sat : '0;
        q_cmd.flag = 1'b0;
        q_cmd.kind = CMD_FLAG;

        // resolve out-of-bounds centers and the unused mode to a bare flag
        unique case (mode)
            MODE_HIT:
            begin
                q_cmd.kind = center_in ? CMD_HIT : CMD_FLAG;
                q_cmd.flag = !center_in;
            end
            MODE_MISS:
            begin
                q_cmd.kind = center_in ? CMD_MISS : CMD_FLAG;
                q_cmd.flag = !center_in;
            end
            MODE_QUERY:
            begin
                q_cmd.kind = center_in ? CMD_QUERY : CMD_FLAG;
                q_cmd.flag = !center_in;
            end
            default:
            begin
                q_cmd.kind = CMD_FLAG;
                q_cmd.flag = 1'b0;
            end
        endcase
    end

    assign in_stall = clearing || q_full;
    assign q_push   = in_valid && !in_stall;

endmodule

`default_nettype wire

@@ hdl/occ_cmdq.sv @@
`default_nettype none

module occ_cmdq import occ_pkg::*; (
    input  wire logic push,
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output cmd_t      pop_cmd,
    output logic      empty
);

    // pointers wrap naturally, so the depth is a power of two
    localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;

    cmd_t          entry_reg [CMDQ_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + {{PW{1'b0}}, push} - {{PW{1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full    = (count_reg == (PW+1)'(CMDQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

@@ hdl/occ_back.sv @@
`default_nettype none

module occ_back import occ_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_empty,
    input  wire cmd_t q_cmd,
    output logic      q_pop,
    output logic      clearing,
    output logic      out_valid,
    input  wire logic out_stall,
    output logic      flag
);

    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(GRID_SIDE);
    localparam int DW    = RAD_W + 1;
    localparam logic signed [CRD_W-1:0] SIDE_S   = CRD_W'(GRID_SIDE);
    localparam logic [AW-1:0]           LAST_ADR = AW'(DEPTH - 1);

    // update visits the center, then the four neighbours
    localparam logic [2:0] STEP_CENTER = 3'd0;
    localparam logic [2:0] STEP_XP     = 3'd1;
    localparam logic [2:0] STEP_XM     = 3'd2;
    localparam logic [2:0] STEP_YP     = 3'd3;
    localparam logic [2:0] STEP_YM     = 3'd4;

    function automatic logic [AW-1:0] cell_addr(
        input logic signed [CRD_W-1:0] cx,
        input logic signed [CRD_W-1:0] cy
    );
        logic [AW-1:0] row;
        row = AW'(cx[CW-1:0]) * AW'(GRID_SIDE);
        return row + AW'(cy[CW-1:0]);
    endfunction

    back_state_t              state_reg, state_next;
    cmd_t                     cmd_reg, cmd_next;
    logic [2:0]               step_reg, step_next;
    logic signed [DW-1:0]     dx_reg, dx_next;
    logic signed [DW-1:0]     dy_reg, dy_next;
    logic                     pend_reg, pend_next;
    logic                     pend_center_reg, pend_center_next;
    logic [AW-1:0]            pend_addr_reg, pend_addr_next;
    logic                     hit_reg, hit_next;
    logic [AW-1:0]            clr_addr_reg, clr_addr_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     flag_reg, flag_next;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [CELL_W-1:0]        ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic [CELL_W-1:0]        ram_rdata;
    logic signed [CELL_W-1:0] cell_rd;

    logic signed [SUM_W-1:0]  base;
    logic signed [SUM_W-1:0]  delta;
    logic signed [CELL_W-1:0] new_val;
    logic signed [CRD_W-1:0]  tx, ty;
    logic signed [DW-1:0]     rad_pos, rad_neg, q_rad_neg;
    logic                     tgt_in;

    occ_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cell_rd = $signed(ram_rdata);

    // new cell value for the read that returns this cycle
    always_comb
    begin
        if (cell_rd == CELL_UNKNOWN)
        begin
            base = '0;
        end
        else
        begin
            base = SUM_W'(cell_rd);
        end
        if (pend_center_reg && (base < SUM_W'(CELL_FLOOR_PRE)))
        begin
            base = SUM_W'(CELL_FLOOR_PRE);
        end
        if (pend_center_reg)
        begin
            delta = CENTER_STEP;
        end
        else
        begin
            delta = NEIGHBOUR_STEP;
        end
        if (cmd_reg.kind == CMD_MISS)
        begin
            delta = -delta;
        end
        new_val = clamp_cell(base + delta);
    end

    assign rad_pos   = $signed({1'b0, cmd_reg.rad});
    assign rad_neg   = -$signed({1'b0, cmd_reg.rad});
    assign q_rad_neg = -$signed({1'b0, q_cmd.rad});

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        step_next        = step_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        pend_next        = 1'b0;
        pend_center_next = 1'b0;
        pend_addr_next   = pend_addr_reg;
        hit_next         = hit_reg;
        clr_addr_next    = clr_addr_reg;
        out_valid_next   = out_valid_reg && out_stall;
        flag_next        = flag_reg;
        q_pop            = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = pend_addr_reg;
        ram_wdata        = new_val;
        tx               = CRD_W'(cmd_reg.x);
        ty               = CRD_W'(cmd_reg.y);

        // retire the read issued last cycle: write back or compare
        if (pend_reg)
        begin
            if (cmd_reg.kind == CMD_QUERY)
            begin
                if (cell_rd > cmd_reg.thr)
                begin
                    hit_next = 1'b1;
                end
            end
            else
            begin
                ram_we = 1'b1;
            end
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = CELL_UNKNOWN;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    cmd_next  = q_cmd;
                    step_next = STEP_CENTER;
                    dx_next   = q_rad_neg;
                    dy_next   = q_rad_neg;
                    hit_next  = 1'b0;
                    unique case (q_cmd.kind)
                        CMD_FLAG:  state_next = ST_RESULT;
                        CMD_HIT:   state_next = ST_UPDATE;
                        CMD_MISS:  state_next = ST_UPDATE;
                        CMD_QUERY: state_next = ST_QUERY;
                    endcase
                end
            end
            ST_UPDATE:
            begin
                unique case (step_reg)
                    STEP_CENTER: ;
                    STEP_XP:     tx = CRD_W'(cmd_reg.x) + CRD_W'(1);
                    STEP_XM:     tx = CRD_W'(cmd_reg.x) - CRD_W'(1);
                    STEP_YP:     ty = CRD_W'(cmd_reg.y) + CRD_W'(1);
                    STEP_YM:     ty = CRD_W'(cmd_reg.y) - CRD_W'(1);
                    default:     ;
                endcase
                pend_next        = tgt_in;
                pend_center_next = (step_reg == STEP_CENTER);
                pend_addr_next   = cell_addr(tx, ty);
                step_next        = step_reg + 3'd1;
                if (step_reg == STEP_YM)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_QUERY:
            begin
                tx             = CRD_W'(cmd_reg.x) + CRD_W'(dx_reg);
                ty             = CRD_W'(cmd_reg.y) + CRD_W'(dy_reg);
                pend_next      = tgt_in;
                pend_addr_next = cell_addr(tx, ty);
                // scan rows of the window, column offset innermost
                if (dy_reg == rad_pos)
                begin
                    dy_next = rad_neg;
                    if (dx_reg == rad_pos)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        dx_next = dx_reg + DW'(1);
                    end
                end
                else
                begin
                    dy_next = dy_reg + DW'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    if (cmd_reg.kind == CMD_QUERY)
                    begin
                        flag_next = hit_reg;
                    end
                    else if (cmd_reg.kind == CMD_FLAG)
                    begin
                        flag_next = cmd_reg.flag;
                    end
                    else
                    begin
                        flag_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        ram_raddr = cell_addr(tx, ty);
    end

    assign tgt_in = in_grid(tx, ty, SIDE_S);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            step_reg      <= STEP_CENTER;
            dx_reg        <= '0;
            dy_reg        <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        pend_center_reg <= pend_center_next;
        pend_addr_reg   <= pend_addr_next;
        flag_reg        <= flag_next;
    end

    assign clearing  = (state_reg == ST_CLEAR);
    assign out_valid = out_valid_reg;
    assign flag      = flag_reg;

endmodule

`default_nettype wire

@@ hdl/occ_checker.sv @@
`default_nettype none

module occ_checker import occ_pkg::*; (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic flag
);

    // queue, back end and output register each hold at most their share
    localparam int MAX_PEND = CMDQ_DEPTH + 2;
    localparam int PCW      = $clog2(MAX_PEND + 1);

    logic           in_take;
    logic           out_take;
    logic [PCW-1:0] pend_reg, pend_next;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;

    always_comb
    begin
        pend_next = pend_reg + PCW'(in_take) - PCW'(out_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(flag))
        else $error("result dropped or changed while stalled");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != '0)
        else $error("result offered with no item outstanding");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= PCW'(MAX_PEND))
        else $error("more items outstanding than the block can hold");

    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_stall)
        else $error("item taken before the clearing pass");

endmodule

bind occupancy_costmap_update_query occ_checker u_occ_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .flag      (flag)
);

`default_nettype wire

@@ verif/occupancy_costmap_update_query_checker.sv @@
`timescale 1ns / 100ps

module occupancy_costmap_update_query_checker import occ_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic [1:0]                mode,
    input  logic signed [POS_W-1:0]   pos_x,
    input  logic signed [POS_W-1:0]   pos_y,
    input  logic signed [CELL_W-1:0]  threshold,
    input  logic                      use_window,
    input  logic [RAD_IN_W-1:0]       window_radius,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic                      flag,
    output int                        err_count,
    output int                        outstanding
);

    localparam int REPORT_LIMIT = 100;

    typedef struct {
        logic                     flag;
        logic [1:0]               mode;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
    } flag_expect_t;

    // Shadow copy of the costmap, every cell unknown at start
    logic signed [CELL_W-1:0] cost_map [GRID_SIDE*GRID_SIDE];
    flag_expect_t             pending_flags [$];

    initial
    begin
        err_count   = 0;
        outstanding = 0;
        for (int i = 0; i < GRID_SIDE * GRID_SIDE; i++)
        begin
            cost_map[i] = CELL_UNKNOWN;
        end
    end

    task automatic report_mismatch(input string what);
        if (err_count < REPORT_LIMIT)
        begin
            $display("%0t ns: %s", $time, what);
        end
        err_count++;
    endtask

    function automatic bit on_grid(input int cx, input int cy);
        return (cx >= 0) && (cy >= 0) && (cx < GRID_SIDE) && (cy < GRID_SIDE);
    endfunction

    function automatic int cell_index(input int cx, input int cy);
        return cx * GRID_SIDE + cy;
    endfunction

    function automatic logic signed [CELL_W-1:0] saturate_cost(input int v);
        if (v < CELL_MIN)
        begin
            return CELL_MIN;
        end
        if (v > CELL_MAX)
        begin
            return CELL_MAX;
        end
        return CELL_W'(v);
    endfunction

    function automatic void nudge_neighbour(input int cx, input int cy, input int step);
        int prior;
        if (!on_grid(cx, cy))
        begin
            return;
        end
        prior = int'(cost_map[cell_index(cx, cy)]);
        if (prior == CELL_UNKNOWN)
        begin
            prior = 0;
        end
        cost_map[cell_index(cx, cy)] = saturate_cost(prior + step);
    endfunction

    function automatic bit window_blocked(input int cx, input int cy, input int lim,
                                          input int reach);
        for (int dx = -reach; dx <= reach; dx++)
        begin
            for (int dy = -reach; dy <= reach; dy++)
            begin
                if (on_grid(cx + dx, cy + dy) && cost_map[cell_index(cx + dx, cy + dy)] > lim)
                begin
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Apply one command to the shadow map and return the flag it should produce
    function automatic bit apply_command(
        input logic [1:0]               m,
        input logic signed [POS_W-1:0]  px,
        input logic signed [POS_W-1:0]  py,
        input logic signed [CELL_W-1:0] thr,
        input logic                     win,
        input logic [RAD_IN_W-1:0]      rad
    );
        int cx;
        int cy;
        int lim;
        int reach;
        int mid;
        int c_step;
        int n_step;
        cx    = int'(px);
        cy    = int'(py);
        lim   = int'(thr);
        reach = int'(rad);
        if (reach > MAX_WINDOW_RADIUS)
        begin
            reach = MAX_WINDOW_RADIUS;
        end
        case (m)
            MODE_HIT, MODE_MISS:
            begin
                if (!on_grid(cx, cy))
                begin
                    return 1'b1;
                end
                c_step = int'(CENTER_STEP);
                n_step = int'(NEIGHBOUR_STEP);
                if (m == MODE_MISS)
                begin
                    c_step = -c_step;
                    n_step = -n_step;
                end
                mid = int'(cost_map[cell_index(cx, cy)]);
                if (mid == CELL_UNKNOWN)
                begin
                    mid = 0;
                end
                if (mid < CELL_FLOOR_PRE)
                begin
                    mid = int'(CELL_FLOOR_PRE);
                end
                nudge_neighbour(cx + 1, cy, n_step);
                nudge_neighbour(cx - 1, cy, n_step);
                nudge_neighbour(cx, cy + 1, n_step);
                nudge_neighbour(cx, cy - 1, n_step);
                cost_map[cell_index(cx, cy)] = saturate_cost(mid + c_step);
                return 1'b0;
            end
            MODE_QUERY:
            begin
                if (!on_grid(cx, cy))
                begin
                    return 1'b1;
                end
                if (cost_map[cell_index(cx, cy)] > lim)
                begin
                    return 1'b1;
                end
                return win && window_blocked(cx, cy, lim, reach);
            end
            default:
            begin
                return 1'b0;
            end
        endcase
    endfunction

    // Compare results before taking a new item, so a result can never match
    // the item accepted at the same edge.
    always @(posedge clk)
    begin : watch_channels
        flag_expect_t want;
        flag_expect_t got_cmd;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_flags.size() == 0)
                begin
                    report_mismatch($sformatf("flag=%0b arrived with no item pending", flag));
                end
                else
                begin
                    want = pending_flags.pop_front();
                    if (flag !== want.flag)
                    begin
                        report_mismatch($sformatf("mode %0d at (%0d,%0d): flag=%b, want %0b",
                                                  want.mode, want.x, want.y, flag, want.flag));
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                got_cmd.mode = mode;
                got_cmd.x    = pos_x;
                got_cmd.y    = pos_y;
                got_cmd.flag = apply_command(mode, pos_x, pos_y, threshold, use_window,
                                             window_radius);
                pending_flags.push_back(got_cmd);
            end
            outstanding <= pending_flags.size();
        end
    end

endmodule

@@ verif/occupancy_costmap_update_query_tb.sv @@
`timescale 1ns / 100ps

module occupancy_costmap_update_query_tb;
    import occ_pkg::*;

    localparam int SIDE             = GRID_SIDE_DEF;
    localparam int RESET_CYCLES     = 9;
    localparam int ITEMS_PER_PHASE  = 400;
    // Long receiver hold-off, placed in the phase where the sender never idles
    localparam int HOLD_AT_RESULT   = 550;
    localparam int LONG_HOLD_CYCLES = 400;
    // Idle time at the end, longer than the longest query, a (2*4+1)^2-cell window scan
    localparam int TAIL_CYCLES      = 100;
    // Run limit: the clearing pass over 65536 cells plus about 1650 items with full
    // idling, with a wide margin.
    localparam int CYCLE_LIMIT      = 1_000_000;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]               mode;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [CELL_W-1:0] thr;
        logic                     win;
        logic [RAD_IN_W-1:0]      rad;
    } costmap_cmd_t;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      in_valid      = 1'b0;
    logic                      in_stall;
    logic [1:0]                mode          = MODE_HIT;
    logic signed [POS_W-1:0]   pos_x         = '0;
    logic signed [POS_W-1:0]   pos_y         = '0;
    logic signed [CELL_W-1:0]  threshold     = '0;
    logic                      use_window    = 1'b0;
    logic [RAD_IN_W-1:0]       window_radius = '0;
    logic                      out_valid;
    logic                      out_stall     = 1'b0;
    logic                      flag;

    int err_count;
    int outstanding;
    int cycle_count = 0;

    // Upper bounds for the per-item idle draws; changed between phases
    int tx_idle_max = 5;
    int rx_idle_max = 5;

    always #6 clk = ~clk;

    occupancy_costmap_update_query i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .threshold     (threshold),
        .use_window    (use_window),
        .window_radius (window_radius),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .flag          (flag)
    );

    occupancy_costmap_update_query_checker #(
        .GRID_SIDE (SIDE)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .threshold     (threshold),
        .use_window    (use_window),
        .window_radius (window_radius),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .flag          (flag),
        .err_count     (err_count),
        .outstanding   (outstanding)
    );

    function automatic costmap_cmd_t make_cmd(input logic [1:0] m, input int cx, input int cy,
                                              input int thr, input logic win, input int rad);
        costmap_cmd_t c;
        c.mode = m;
        c.x    = POS_W'(cx);
        c.y    = POS_W'(cy);
        c.thr  = CELL_W'(thr);
        c.win  = win;
        c.rad  = RAD_IN_W'(rad);
        return c;
    endfunction

    // Coordinates lean on a few small clusters (corner, middle, far edge) so
    // that cells see repeated hits and misses and reach both clamps; the rest
    // covers the whole grid, its border and the full signed field.
    function automatic int pick_coord();
        case ($urandom_range(0, 9))
            0, 1:
            begin
                return $urandom_range(0, 2047);
            end
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       return -1;
                    1:       return 0;
                    2:       return SIDE - 1;
                    default: return SIDE;
                endcase
            end
            3:
            begin
                return $urandom_range(0, SIDE - 1);
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0:       return $urandom_range(0, 3);
                    1:       return SIDE / 2 + $urandom_range(0, 3);
                    default: return SIDE - 4 + $urandom_range(0, 3);
                endcase
            end
        endcase
    endfunction

    function automatic costmap_cmd_t random_cmd();
        costmap_cmd_t c;
        int           pick;
        pick = $urandom_range(0, 19);
        if (pick < 8)
        begin
            c.mode = MODE_HIT;
        end
        else if (pick < 13)
        begin
            c.mode = MODE_MISS;
        end
        else if (pick < 19)
        begin
            c.mode = MODE_QUERY;
        end
        else
        begin
            c.mode = MODE_UNUSED;
        end
        c.x = POS_W'(pick_coord());
        c.y = POS_W'(pick_coord());
        // Mostly thresholds in the cost range, now and then the whole field
        if ($urandom_range(0, 9) == 0)
        begin
            c.thr = CELL_W'($urandom_range(0, 511));
        end
        else
        begin
            c.thr = CELL_W'($urandom_range(0, 300) - 100);
        end
        c.win = 1'($urandom_range(0, 1));
        c.rad = RAD_IN_W'($urandom_range(0, 7));
        return c;
    endfunction

    // Offer one item, hold it until accepted, then idle for a random gap.
    // With a zero gap valid stays high for the next item.
    task automatic send_cmd(input costmap_cmd_t c);
        int gap;
        in_valid      <= 1'b1;
        mode          <= c.mode;
        pos_x         <= c.x;
        pos_y         <= c.y;
        threshold     <= c.thr;
        use_window    <= c.win;
        window_radius <= c.rad;
        do
            @(posedge clk);
        while (in_stall);
        gap = $urandom_range(0, tx_idle_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and hold until every expected result has been taken
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Result side: stall a random number of cycles before each result, with
    // one long hold-off so the block backs up and stalls its input.
    initial
    begin : result_sink
        int stall_cycles;
        int results_taken;
        results_taken = 0;
        wait (rst_n);
        forever
        begin
            if (results_taken == HOLD_AT_RESULT)
            begin
                stall_cycles = LONG_HOLD_CYCLES;
            end
            else
            begin
                stall_cycles = $urandom_range(0, rx_idle_max);
            end
            if (stall_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            results_taken++;
        end
    end

    // Watchdog: end the run if it hangs
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("occupancy_costmap_update_query test failed");
        $finish;
    end

    initial
    begin : stimulus
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. An unknown cell compares as -100: equal threshold
        // does not trip, the most negative threshold does.
        send_cmd(make_cmd(MODE_QUERY, 0, 0, -100, 1'b0, 0));
        send_cmd(make_cmd(MODE_QUERY, 0, 0, -256, 1'b0, 0));
        // Hits on the corner: only two neighbours in bounds, center saturates at 200
        repeat (5) send_cmd(make_cmd(MODE_HIT, 0, 0, 0, 1'b0, 0));
        send_cmd(make_cmd(MODE_QUERY, 0, 0, 199, 1'b0, 0));
        send_cmd(make_cmd(MODE_QUERY, 0, 0, 255, 1'b1, 0));
        // Misses on the far corner drive the center to the lower clamp
        repeat (4) send_cmd(make_cmd(MODE_MISS, SIDE - 1, SIDE - 1, 0, 1'b0, 0));
        // A center below -90 is raised to -90 before the hit is added
        send_cmd(make_cmd(MODE_HIT, SIDE - 1, SIDE - 1, 0, 1'b0, 0));
        // Out-of-bounds centers on update and query, field extremes included
        send_cmd(make_cmd(MODE_HIT, -1, 0, 0, 1'b0, 0));
        send_cmd(make_cmd(MODE_MISS, SIDE, SIDE - 1, 0, 1'b0, 0));
        send_cmd(make_cmd(MODE_HIT, -1024, 1023, 0, 1'b0, 0));
        send_cmd(make_cmd(MODE_QUERY, 1023, -1024, 255, 1'b1, 7));
        send_cmd(make_cmd(MODE_QUERY, -1, 5, 255, 1'b0, 0));
        // Unused mode with every field at an extreme
        send_cmd(make_cmd(MODE_UNUSED, 1023, -1024, -256, 1'b1, 7));
        // Window: oversized radius saturates to 4 and reaches the hot corner,
        // radius 3 falls one cell short of it
        send_cmd(make_cmd(MODE_QUERY, 4, 4, 100, 1'b1, 7));
        send_cmd(make_cmd(MODE_QUERY, 4, 4, 100, 1'b1, 3));
        send_cmd(make_cmd(MODE_QUERY, 4, 4, 100, 1'b1, 4));
        send_cmd(make_cmd(MODE_QUERY, 2, 2, 100, 1'b0, 7));
        send_cmd(make_cmd(MODE_QUERY, SIDE / 2, SIDE / 2, -101, 1'b1, 0));
        wait_for_results();

        // Random part in four phases with different idling on each side;
        // the sender pauses between phases until all results are in.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_max = 5;
                    rx_idle_max = 5;
                end
                1:
                begin
                    tx_idle_max = 0;
                    rx_idle_max = 0;
                end
                2:
                begin
                    tx_idle_max = 5;
                    rx_idle_max = 0;
                end
                default:
                begin
                    tx_idle_max = 0;
                    rx_idle_max = 5;
                end
            endcase
            repeat (ITEMS_PER_PHASE) send_cmd(random_cmd());
            wait_for_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0 && outstanding == 0)
        begin
            $display("occupancy_costmap_update_query test passed");
        end
        else
        begin
            $display("occupancy_costmap_update_query test failed");
        end
        $finish;
    end

endmodule
